// ----- rtl/tif_pkg.sv -----
// Package with the types, constants and tables of the twin interference factor unit.
package tif_pkg;

  localparam int APPROX_STAGES = 20;

  localparam int CORDIC_IW = (APPROX_STAGES > 1) ? $clog2(APPROX_STAGES) : 1;
  localparam int HORNER_KW = $clog2(APPROX_STAGES + 1);

  localparam int SQRT_CELLS = 30;
  localparam int DIV_CELLS = 31;

  localparam logic [33:0] CORDIC_GAIN = 34'h026DD3B6A;
  localparam logic [57:0] INV_TWO_PI_Q60 = 58'h28BE60DB9391055;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef enum logic [2:0] {
    REG_DIR_X      = 3'd0,
    REG_DIR_Y      = 3'd1,
    REG_DIR_Z      = 3'd2,
    REG_SEPARATION = 3'd3,
    REG_SPREAD     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
  } q_item_t;

  typedef struct packed {
    logic [18:0] factor;
    logic        bad_direction;
  } res_item_t;

  typedef struct packed {
    logic [59:0] v;
    logic [59:0] root;
    logic [59:0] probe;
  } sqrt_rec_t;

  typedef struct packed {
    logic        bad;
    logic [47:0] mag;
  } sqrt_side_t;

  typedef struct packed {
    logic [60:0] rem;
    logic [59:0] den;
    logic [30:0] quo;
  } div_rec_t;

  typedef struct packed {
    logic bad;
    logic sat;
  } div_side_t;

  typedef struct packed {
    logic signed [33:0]     x;
    logic signed [33:0]     y;
    logic signed [33:0]     z;
    logic [CORDIC_IW-1:0]   iter;
  } cordic_rec_t;

  typedef struct packed {
    logic        bad;
    logic        neg;
    logic        exp_zero;
    logic [5:0]  shift;
    logic [29:0] t;
  } cordic_side_t;

  typedef struct packed {
    logic [30:0]          r;
    logic [HORNER_KW-1:0] k;
    logic [29:0]          t;
  } horner_rec_t;

  typedef struct packed {
    logic        bad;
    logic        exp_zero;
    logic [5:0]  shift;
    logic        cneg;
    logic [17:0] cabs;
  } horner_side_t;

  // Arctangent of 2^-i in Q0.32 turns.
  function automatic logic [31:0] atan_turns(input logic [CORDIC_IW-1:0] i);
    logic [4:0] idx;
    idx = 5'(i);
    case (idx)
      5'd0:  atan_turns = 32'h20000000;
      5'd1:  atan_turns = 32'h12E4051E;
      5'd2:  atan_turns = 32'h09FB385B;
      5'd3:  atan_turns = 32'h051111D4;
      5'd4:  atan_turns = 32'h028B0D43;
      5'd5:  atan_turns = 32'h0145D7E1;
      5'd6:  atan_turns = 32'h00A2F61E;
      5'd7:  atan_turns = 32'h00517C55;
      5'd8:  atan_turns = 32'h0028BE53;
      5'd9:  atan_turns = 32'h00145F2F;
      5'd10: atan_turns = 32'h000A2F98;
      5'd11: atan_turns = 32'h000517CC;
      5'd12: atan_turns = 32'h00028BE6;
      5'd13: atan_turns = 32'h000145F3;
      5'd14: atan_turns = 32'h0000A2FA;
      5'd15: atan_turns = 32'h0000517D;
      5'd16: atan_turns = 32'h000028BE;
      5'd17: atan_turns = 32'h0000145F;
      5'd18: atan_turns = 32'h00000A30;
      5'd19: atan_turns = 32'h00000518;
      5'd20: atan_turns = 32'h0000028C;
      5'd21: atan_turns = 32'h00000146;
      5'd22: atan_turns = 32'h000000A3;
      5'd23: atan_turns = 32'h00000051;
      5'd24: atan_turns = 32'h00000029;
      5'd25: atan_turns = 32'h00000014;
      5'd26: atan_turns = 32'h0000000A;
      5'd27: atan_turns = 32'h00000005;
      5'd28: atan_turns = 32'h00000003;
      5'd29: atan_turns = 32'h00000001;
      5'd30: atan_turns = 32'h00000001;
      default: atan_turns = 32'h00000000;
    endcase
  endfunction

  // Reciprocal floor(2^31 / k) for the divisions inside the series.
  function automatic logic [31:0] recip_q31(input logic [HORNER_KW-1:0] k);
    logic [5:0] idx;
    idx = 6'(k);
    case (idx)
      6'd1:  recip_q31 = 32'd2147483648;
      6'd2:  recip_q31 = 32'd1073741824;
      6'd3:  recip_q31 = 32'd715827882;
      6'd4:  recip_q31 = 32'd536870912;
      6'd5:  recip_q31 = 32'd429496729;
      6'd6:  recip_q31 = 32'd357913941;
      6'd7:  recip_q31 = 32'd306783378;
      6'd8:  recip_q31 = 32'd268435456;
      6'd9:  recip_q31 = 32'd238609294;
      6'd10: recip_q31 = 32'd214748364;
      6'd11: recip_q31 = 32'd195225786;
      6'd12: recip_q31 = 32'd178956970;
      6'd13: recip_q31 = 32'd165191049;
      6'd14: recip_q31 = 32'd153391689;
      6'd15: recip_q31 = 32'd143165576;
      6'd16: recip_q31 = 32'd134217728;
      6'd17: recip_q31 = 32'd126322567;
      6'd18: recip_q31 = 32'd119304647;
      6'd19: recip_q31 = 32'd113025455;
      6'd20: recip_q31 = 32'd107374182;
      6'd21: recip_q31 = 32'd102261126;
      6'd22: recip_q31 = 32'd97612893;
      6'd23: recip_q31 = 32'd93368854;
      6'd24: recip_q31 = 32'd89478485;
      6'd25: recip_q31 = 32'd85899345;
      6'd26: recip_q31 = 32'd82595524;
      6'd27: recip_q31 = 32'd79536431;
      6'd28: recip_q31 = 32'd76695844;
      6'd29: recip_q31 = 32'd74051160;
      6'd30: recip_q31 = 32'd71582788;
      6'd31: recip_q31 = 32'd69273666;
      6'd32: recip_q31 = 32'd67108864;
      default: recip_q31 = 32'd0;
    endcase
  endfunction

endpackage

// ----- rtl/tif_sqrt_cell.sv -----
// One digit step of the pipelined integer square root.
module tif_sqrt_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  tif_pkg::sqrt_rec_t     in_rec,
  input  tif_pkg::sqrt_side_t    in_side,
  output logic                   out_valid,
  output tif_pkg::sqrt_rec_t     out_rec,
  output tif_pkg::sqrt_side_t    out_side
);

  logic [60:0]        trial;
  tif_pkg::sqrt_rec_t rec_next;

  always_comb begin
    trial = 61'(in_rec.root) + 61'(in_rec.probe);
    rec_next.probe = in_rec.probe >> 2;
    if ({1'b0, in_rec.v} >= trial) begin
      rec_next.v = in_rec.v - trial[59:0];
      rec_next.root = (in_rec.root >> 1) + in_rec.probe;
    end else begin
      rec_next.v = in_rec.v;
      rec_next.root = in_rec.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec <= rec_next;
      out_side <= in_side;
    end
  end

endmodule

// ----- rtl/tif_div_cell.sv -----
// One quotient bit of the pipelined restoring divider.
module tif_div_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  tif_pkg::div_rec_t     in_rec,
  input  tif_pkg::div_side_t    in_side,
  output logic                  out_valid,
  output tif_pkg::div_rec_t     out_rec,
  output tif_pkg::div_side_t    out_side
);

  tif_pkg::div_rec_t rec_next;

  always_comb begin
    rec_next.den = in_rec.den >> 1;
    if (in_rec.rem >= {1'b0, in_rec.den}) begin
      rec_next.rem = in_rec.rem - {1'b0, in_rec.den};
      rec_next.quo = {in_rec.quo[29:0], 1'b1};
    end else begin
      rec_next.rem = in_rec.rem;
      rec_next.quo = {in_rec.quo[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec <= rec_next;
      out_side <= in_side;
    end
  end

endmodule

// ----- rtl/tif_cordic_cell.sv -----
// One rotation of the pipelined cosine CORDIC.
module tif_cordic_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  tif_pkg::cordic_rec_t    in_rec,
  input  tif_pkg::cordic_side_t   in_side,
  output logic                    out_valid,
  output tif_pkg::cordic_rec_t    out_rec,
  output tif_pkg::cordic_side_t   out_side
);

  logic signed [33:0]   dx;
  logic signed [33:0]   dy;
  logic signed [33:0]   ang;
  tif_pkg::cordic_rec_t rec_next;

  always_comb begin
    dx = in_rec.y >>> in_rec.iter;
    dy = in_rec.x >>> in_rec.iter;
    ang = 34'(tif_pkg::atan_turns(in_rec.iter));
    rec_next.iter = in_rec.iter + 1'b1;
    if (!in_rec.z[33]) begin
      rec_next.x = in_rec.x - dx;
      rec_next.y = in_rec.y + dy;
      rec_next.z = in_rec.z - ang;
    end else begin
      rec_next.x = in_rec.x + dx;
      rec_next.y = in_rec.y - dy;
      rec_next.z = in_rec.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec <= rec_next;
      out_side <= in_side;
    end
  end

endmodule

// ----- rtl/tif_horner_cell.sv -----
// One term of the exponential series, evaluated over three pipeline stages.
module tif_horner_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  tif_pkg::horner_rec_t    in_rec,
  input  tif_pkg::horner_side_t   in_side,
  output logic                    out_valid,
  output tif_pkg::horner_rec_t    out_rec,
  output tif_pkg::horner_side_t   out_side
);

  localparam int KW = tif_pkg::HORNER_KW;

  logic                    v1;
  logic [60:0]             wprod;
  logic [KW-1:0]           k1;
  logic [29:0]             t1;
  tif_pkg::horner_side_t   side1;

  logic                    v2;
  logic [29:0]             w2;
  logic [61:0]             qm2;
  logic [KW-1:0]           k2;
  logic [29:0]             t2;
  tif_pkg::horner_side_t   side2;

  logic [29:0]             q0;
  logic [29+KW:0]          qk;
  logic [29+KW:0]          rem;
  logic [29:0]             quot;

  always_comb begin
    q0 = qm2[60:31];
    qk = (30 + KW)'(q0) * (30 + KW)'(k2);
    rem = (30 + KW)'(w2) - qk;
    quot = (rem >= (30 + KW)'(k2)) ? q0 + 30'd1 : q0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wprod <= 61'(in_rec.t) * 61'(in_rec.r);
      k1 <= in_rec.k;
      t1 <= in_rec.t;
      side1 <= in_side;

      w2 <= wprod[59:30];
      qm2 <= 62'(wprod[59:30]) * 62'(tif_pkg::recip_q31(k1));
      k2 <= k1;
      t2 <= t1;
      side2 <= side1;

      out_rec.r <= tif_pkg::ONE_Q30 - 31'(quot);
      out_rec.k <= k2 - 1'b1;
      out_rec.t <= t2;
      out_side <= side2;
    end
  end

endmodule

// ----- rtl/twin_interference_factor_unit.sv -----
// Top level of the twin interference factor unit: front end, cell chains and output register.
//
//   Channel  Direction  Handshake            Payload
//   q        in         q_valid / q_stall    q_x, q_y, q_z
//   res      out        res_valid / res_stall  factor, bad_direction
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// One transaction is accepted every cycle while the pipeline does not hold; results pass
// through the square root, divider, CORDIC and series cell chains.
// Reset clears all valid bits and loads the register reset values.
// The pipeline holds only when its last stage and the output register both carry
// a result and res_stall is high; q_stall follows that condition.
module twin_interference_factor_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_stall,
  input  tif_pkg::q_item_t     q,
  output logic                 res_valid,
  input  logic                 res_stall,
  output tif_pkg::res_item_t   res,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data
);

  localparam int NS = tif_pkg::SQRT_CELLS;
  localparam int ND = tif_pkg::DIV_CELLS;
  localparam int NC = tif_pkg::APPROX_STAGES;

  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [23:0]        separation;
  logic [23:0]        spread;

  logic adv;
  logic out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x <= 16'sd16384;
      dir_y <= 16'sd0;
      dir_z <= 16'sd0;
      separation <= 24'd0;
      spread <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tif_pkg::REG_DIR_X:      dir_x <= cfg_data[15:0];
        tif_pkg::REG_DIR_Y:      dir_y <= cfg_data[15:0];
        tif_pkg::REG_DIR_Z:      dir_z <= cfg_data[15:0];
        tif_pkg::REG_SEPARATION: separation <= cfg_data;
        tif_pkg::REG_SPREAD:     spread <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: products. Stage B: sums. Stage C: magnitude and root setup.
  logic               va;
  logic signed [47:0] px, py, pz;
  logic [31:0]        sxx, syy, szz;
  logic               vb;
  logic signed [49:0] dot;
  logic [31:0]        mag2;
  logic               vc;
  tif_pkg::sqrt_rec_t  c_rec;
  tif_pkg::sqrt_side_t c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      va <= q_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= 48'(q.q_x * dir_x);
      py <= 48'(q.q_y * dir_y);
      pz <= 48'(q.q_z * dir_z);
      sxx <= 32'(dir_x * dir_x);
      syy <= 32'(dir_y * dir_y);
      szz <= 32'(dir_z * dir_z);

      dot <= 50'(px) + 50'(py) + 50'(pz);
      mag2 <= sxx + syy + szz;

      c_side.bad <= (mag2 == 32'd0);
      c_side.mag <= 48'(dot[49] ? -dot : dot);
      c_rec.v <= {mag2, 28'd0};
      c_rec.root <= 60'd0;
      c_rec.probe <= 60'd1 << (2 * (NS - 1));
    end
  end

  logic                sq_v    [NS+1];
  tif_pkg::sqrt_rec_t  sq_rec  [NS+1];
  tif_pkg::sqrt_side_t sq_side [NS+1];

  assign sq_v[0] = vc;
  assign sq_rec[0] = c_rec;
  assign sq_side[0] = c_side;

  for (genvar i = 0; i < NS; i++) begin : g_sqrt
    tif_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (sq_v[i]),
      .in_rec    (sq_rec[i]),
      .in_side   (sq_side[i]),
      .out_valid (sq_v[i+1]),
      .out_rec   (sq_rec[i+1]),
      .out_side  (sq_side[i+1])
    );
  end

  // Stage D: rounded numerator and saturation check.
  logic [29:0]        nrm;
  logic [61:0]        num;
  logic               vd;
  tif_pkg::div_rec_t  d_rec;
  tif_pkg::div_side_t d_side;

  always_comb begin
    nrm = sq_rec[NS].root[29:0];
    num = {sq_side[NS].mag, 14'd0} + 62'(nrm >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= sq_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_side.bad <= sq_side[NS].bad;
      d_side.sat <= (num >= {1'b0, nrm, 31'd0});
      d_rec.rem <= num[60:0];
      d_rec.den <= {nrm, 30'd0};
      d_rec.quo <= 31'd0;
    end
  end

  logic               dv_v    [ND+1];
  tif_pkg::div_rec_t  dv_rec  [ND+1];
  tif_pkg::div_side_t dv_side [ND+1];

  assign dv_v[0] = vd;
  assign dv_rec[0] = d_rec;
  assign dv_side[0] = d_side;

  for (genvar i = 0; i < ND; i++) begin : g_div
    tif_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (dv_v[i]),
      .in_rec    (dv_rec[i]),
      .in_side   (dv_side[i]),
      .out_valid (dv_v[i+1]),
      .out_rec   (dv_rec[i+1]),
      .out_side  (dv_side[i+1])
    );
  end

  // Stages E1 to E5: phase and exponent argument, then CORDIC setup.
  logic [30:0] proj;
  logic        ve1, ve2, ve3, ve4, ve5;
  logic        bad1, bad2, bad3, bad4;
  logic [54:0] ea, eps;
  logic [56:0] pp00, pp01;
  logic [55:0] pp10, pp11;
  logic        ez2, ez3, ez4;
  logic [61:0] sq;
  logic [87:0] s_lo, s_hi, phase_sum;
  logic [63:0] yprod;
  logic [31:0] phase;
  logic [5:0]  shift4;
  logic [61:0] tprod;
  logic        fold;

  tif_pkg::cordic_rec_t  e_rec;
  tif_pkg::cordic_side_t e_side;

  always_comb begin
    proj = dv_side[ND].sat ? 31'h7FFF_FFFF : dv_rec[ND].quo;
    phase_sum = s_lo + s_hi;
    fold = phase[31] ^ phase[30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve1 <= 1'b0;
      ve2 <= 1'b0;
      ve3 <= 1'b0;
      ve4 <= 1'b0;
      ve5 <= 1'b0;
    end else if (adv) begin
      ve1 <= dv_v[ND];
      ve2 <= ve1;
      ve3 <= ve2;
      ve4 <= ve3;
      ve5 <= ve4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ea <= 55'(proj) * 55'(separation);
      eps <= 55'(proj) * 55'(spread);
      bad1 <= dv_side[ND].bad;

      pp00 <= 57'(ea[27:0]) * 57'(tif_pkg::INV_TWO_PI_Q60[28:0]);
      pp01 <= 57'(ea[27:0]) * 57'(tif_pkg::INV_TWO_PI_Q60[57:29]);
      pp10 <= 56'(ea[54:28]) * 56'(tif_pkg::INV_TWO_PI_Q60[28:0]);
      pp11 <= 56'(ea[54:28]) * 56'(tif_pkg::INV_TWO_PI_Q60[57:29]);
      ez2 <= (eps >= (55'd6 << 28));
      sq <= 62'(eps[30:0]) * 62'(eps[30:0]);
      bad2 <= bad1;

      s_lo <= 88'(pp00) + (88'(pp01) << 29);
      s_hi <= (88'(pp10) << 28) + (88'(pp11) << 57);
      yprod <= 64'(sq[61:29]) * 64'(tif_pkg::LOG2E_Q30);
      ez3 <= ez2;
      bad3 <= bad2;

      phase <= phase_sum[87:56];
      shift4 <= yprod[63:58];
      tprod <= 62'(yprod[57:26]) * 62'(tif_pkg::LN2_Q30);
      ez4 <= ez3;
      bad4 <= bad3;

      e_rec.x <= tif_pkg::CORDIC_GAIN;
      e_rec.y <= 34'sd0;
      e_rec.z <= 34'($signed(fold ? (phase ^ 32'h8000_0000) : phase));
      e_rec.iter <= '0;
      e_side.bad <= bad4;
      e_side.neg <= fold;
      e_side.exp_zero <= ez4;
      e_side.shift <= shift4;
      e_side.t <= tprod[61:32];
    end
  end

  logic                  cr_v    [NC+1];
  tif_pkg::cordic_rec_t  cr_rec  [NC+1];
  tif_pkg::cordic_side_t cr_side [NC+1];

  assign cr_v[0] = ve5;
  assign cr_rec[0] = e_rec;
  assign cr_side[0] = e_side;

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    tif_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (cr_v[i]),
      .in_rec    (cr_rec[i]),
      .in_side   (cr_side[i]),
      .out_valid (cr_v[i+1]),
      .out_rec   (cr_rec[i+1]),
      .out_side  (cr_side[i+1])
    );
  end

  // Stage G: cosine rounding and clamping, then series setup.
  logic signed [33:0] xr, xcl, cval;
  logic               vg;
  tif_pkg::horner_rec_t  g_rec;
  tif_pkg::horner_side_t g_side;

  always_comb begin
    xr = (cr_rec[NC].x + 34'sd4096) >>> 13;
    if (xr > 34'sd131072) begin
      xcl = 34'sd131072;
    end else if (xr < -34'sd131072) begin
      xcl = -34'sd131072;
    end else begin
      xcl = xr;
    end
    cval = cr_side[NC].neg ? -xcl : xcl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (adv) begin
      vg <= cr_v[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_rec.r <= tif_pkg::ONE_Q30;
      g_rec.k <= tif_pkg::HORNER_KW'(NC);
      g_rec.t <= cr_side[NC].t;
      g_side.bad <= cr_side[NC].bad;
      g_side.exp_zero <= cr_side[NC].exp_zero;
      g_side.shift <= cr_side[NC].shift;
      g_side.cneg <= cval[33];
      g_side.cabs <= 18'(cval[33] ? -cval : cval);
    end
  end

  logic                  hn_v    [NC+1];
  tif_pkg::horner_rec_t  hn_rec  [NC+1];
  tif_pkg::horner_side_t hn_side [NC+1];

  assign hn_v[0] = vg;
  assign hn_rec[0] = g_rec;
  assign hn_side[0] = g_side;

  for (genvar i = 0; i < NC; i++) begin : g_horner
    tif_horner_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (hn_v[i]),
      .in_rec    (hn_rec[i]),
      .in_side   (hn_side[i]),
      .out_valid (hn_v[i+1]),
      .out_rec   (hn_rec[i+1]),
      .out_side  (hn_side[i+1])
    );
  end

  // Stages H1 and H2: exponential scaling and product with the cosine.
  logic        vh1, vh2;
  logic [17:0] e1;
  logic        cneg1, cneg2, badh1, badh2;
  logic [17:0] cabs1;
  logic [35:0] pm;
  logic [31:0] esh;
  logic [18:0] prod;
  logic [19:0] fsum;
  logic [18:0] fval;

  always_comb begin
    esh = (32'(hn_rec[NC].r >> hn_side[NC].shift) + 32'd4096) >> 13;
    prod = 19'((pm + 36'd65536) >> 17);
    if (cneg2) begin
      fsum = (prod >= 19'd131072) ? 20'd0 : 20'd131072 - 20'(prod);
    end else begin
      fsum = 20'd131072 + 20'(prod);
    end
    fval = (fsum > 20'd262144) ? 19'd262144 : fsum[18:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vh1 <= 1'b0;
      vh2 <= 1'b0;
    end else if (adv) begin
      vh1 <= hn_v[NC];
      vh2 <= vh1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1 <= hn_side[NC].exp_zero ? 18'd0 : esh[17:0];
      cneg1 <= hn_side[NC].cneg;
      cabs1 <= hn_side[NC].cabs;
      badh1 <= hn_side[NC].bad;

      pm <= 36'(e1) * 36'(cabs1);
      cneg2 <= cneg1;
      badh2 <= badh1;
    end
  end

  assign out_load = !res_valid || !res_stall;
  assign adv = out_load || !vh2;
  assign q_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= vh2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.factor <= badh2 ? 19'd0 : fval;
      res.bad_direction <= badh2;
    end
  end

endmodule

// ----- rtl/tif_checker.sv -----
// Port-level assertions for the twin interference factor unit and their bind.
module tif_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                q_stall,
  input logic                res_valid,
  input logic                res_stall,
  input tif_pkg::res_item_t  res
);

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bad_direction |-> res.factor == 19'd0)
    else $error("bad direction result carries a nonzero factor");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.factor <= 19'd262144)
    else $error("factor above two");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !q_stall)
    else $error("input stalled while output register is empty");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule

bind twin_interference_factor_unit tif_port_checker u_tif_checker (
  .clk       (clk),
  .rst       (rst),
  .q_stall   (q_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
